/* design/kpq_pkg.sv */
`timescale 1ns / 1ps

package kpq_pkg;

	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CODE_W      = 3;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned KIND_W      = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 1'b1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd500;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd5000;

	// Event codes.
	localparam logic [KIND_W-1:0] EV_NONE        = 2'd0;
	localparam logic [KIND_W-1:0] EV_SHORT       = 2'd1;
	localparam logic [KIND_W-1:0] EV_LONG_START  = 2'd2;
	localparam logic [KIND_W-1:0] EV_LONG_RELEASE = 2'd3;

	// Mark bits of the key byte.
	localparam logic [BYTE_W-1:0] MARK_SHORT = 8'h80;
	localparam logic [BYTE_W-1:0] MARK_LONG  = 8'h40;
	localparam logic [BYTE_W-1:0] MARK_REL   = 8'h20;
	localparam logic [BYTE_W-1:0] CODE_MASK  = 8'h07;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CODE_W-1:0] code;
		logic [BYTE_W-1:0] key_byte;
	} kpq_result_t;

endpackage

/* design/kpq_core.sv */
`timescale 1ns / 1ps

module kpq_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step_en,
	input  logic                           level,
	input  logic [kpq_pkg::CODE_W-1:0]     lines,
	input  logic [kpq_pkg::CFG_W-1:0]      debounce_ticks,
	input  logic [kpq_pkg::CFG_W-1:0]      long_press_ticks,
	output kpq_pkg::kpq_result_t           result
);
	import kpq_pkg::*;

	typedef enum logic [1:0] {
		PH_ARMED,
		PH_CHECK,
		PH_LONG,
		PH_LOCK
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [CFG_W-1:0]  count_q, count_n;
	logic [BYTE_W-1:0] held_q, held_n;
	logic              prev_q;
	logic [KIND_W-1:0] kind_n;

	// One tick of the qualifier, evaluated in the same order as the
	// phases hand over inside a single tick.
	always_comb begin
		phase_n = phase_q;
		count_n = count_q;
		held_n  = held_q;
		kind_n  = EV_NONE;
		if (phase_q == PH_ARMED) begin
			if (level && !prev_q) begin
				phase_n = PH_CHECK;
				count_n = '0;
				held_n  = '0;
			end
		end else begin
			if (phase_n == PH_CHECK) begin
				count_n = count_n + 1'b1;
				if (count_n == debounce_ticks) begin
					if (level) begin
						held_n = {{(BYTE_W-CODE_W){1'b0}}, ~lines};
					end else begin
						phase_n = PH_LOCK;
						count_n = '0;
					end
				end
				if (phase_n == PH_CHECK && count_n > debounce_ticks) begin
					if (!level) begin
						held_n  = held_n | MARK_SHORT;
						phase_n = PH_LOCK;
						count_n = '0;
						kind_n  = EV_SHORT;
					end else if (count_n == long_press_ticks) begin
						held_n  = held_n | MARK_LONG;
						phase_n = PH_LONG;
						count_n = '0;
						kind_n  = EV_LONG_START;
					end
				end
			end
			if (phase_n == PH_LONG && !level) begin
				held_n  = held_n | MARK_REL;
				phase_n = PH_LOCK;
				kind_n  = EV_LONG_RELEASE;
			end
			if (phase_n == PH_LOCK) begin
				count_n = count_n + 1'b1;
				if (count_n == debounce_ticks) begin
					phase_n = PH_ARMED;
					count_n = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ARMED;
			count_q <= '0;
			held_q  <= '0;
			prev_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			count_q <= count_n;
			held_q  <= held_n;
			prev_q  <= level;
		end
	end

	always_comb begin
		result.kind = kind_n;
		if (kind_n != EV_NONE) begin
			result.code     = held_n[CODE_W-1:0];
			result.key_byte = held_n;
		end else begin
			result.code     = '0;
			result.key_byte = '0;
		end
	end

endmodule

/* design/key_press_short_long_qualifier_unit.sv */
`timescale 1ns / 1ps

// Key press qualifier: debounces one key and tells short presses from long.
// Each input transfer is one tick sample: key_pressed (1 = pressed) and the
// three active-low encoder lines. Each tick gives exactly one output transfer:
// event_kind (none, short, long start, long release), key_code and key_byte
// (code with 0x80 short, 0x40 long, 0x20 released marks; zero with no event).
// The input sample lands in a register, one pass of the phase logic runs on
// it, and the result lands in the output register; one tick is taken every
// cycle as long as the receiver does not stall.
// The output register and the input register move together, so a new tick is
// accepted while a result is waiting, as long as the input stage can hand its
// tick on. When the receiver stalls, the result holds and the input register
// fills, then in_ready drops until out_ready returns.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 debounce
// ticks, 1 long press ticks) at the clock edge; write only while idle.
// Reset puts the qualifier in the armed phase with the key taken as
// released, empties both registers and loads 500 and 5000 ticks.

module key_press_short_long_qualifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              key_pressed,
	input  logic [kpq_pkg::CODE_W-1:0]        encoder_lines,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kpq_pkg::KIND_W-1:0]        event_kind,
	output logic [kpq_pkg::CODE_W-1:0]        key_code,
	output logic [kpq_pkg::BYTE_W-1:0]        key_byte,
	input  logic                              cfg_we,
	input  logic [kpq_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [kpq_pkg::CFG_W-1:0]         cfg_data
);
	import kpq_pkg::*;

	logic              valid_s1;
	logic              level_s1;
	logic [CODE_W-1:0] lines_s1;
	logic              out_valid_q;
	kpq_result_t       result_q;
	kpq_result_t       result;
	logic [CFG_W-1:0]  debounce_q;
	logic [CFG_W-1:0]  long_press_q;
	logic              advance;

	// The tick in the input register moves on whenever the output register
	// is empty or its result is being transferred out.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= key_pressed;
			lines_s1 <= encoder_lines;
		end
	end

	// Phase logic; its state steps only when a tick leaves the input stage.
	kpq_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (valid_s1 && advance),
		.level            (level_s1),
		.lines            (lines_s1),
		.debounce_ticks   (debounce_q),
		.long_press_ticks (long_press_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = result_q.kind;
	assign key_code   = result_q.code;
	assign key_byte   = result_q.key_byte;

endmodule

/* test/key_press_short_long_qualifier_unit_tb.sv */
`timescale 1ns / 1ps

module key_press_short_long_qualifier_unit_tb;

	import kpq_pkg::*;

	// Phases of the press qualifier, as the checker tracks them.
	typedef enum logic [1:0] {
		ST_ARMED,
		ST_CHECK,
		ST_LONG,
		ST_LOCK
	} press_phase_t;

	// One tick of key input: the key level and the raw encoder lines.
	typedef struct packed {
		logic              level;
		logic [CODE_W-1:0] lines;
	} key_sample_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   in_valid      = 1'b0;
	logic                   in_ready;
	logic                   key_pressed   = 1'b0;
	logic [CODE_W-1:0]      encoder_lines = '0;
	logic                   out_valid;
	logic                   out_ready     = 1'b0;
	logic [KIND_W-1:0]      event_kind;
	logic [CODE_W-1:0]      key_code;
	logic [BYTE_W-1:0]      key_byte;
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = CFG_DEBOUNCE;
	logic [CFG_W-1:0]       cfg_data      = '0;

	// Ticks waiting to be sent and key events still owed by the block.
	key_sample_t tick_queue[$];
	kpq_result_t expected_events[$];

	// The checker's own copy of the timing registers and qualifier state.
	logic [CFG_W-1:0]  debounce_q;
	logic [CFG_W-1:0]  long_press_q;
	press_phase_t      phase_q;
	logic [CFG_W-1:0]  count_q;
	logic [BYTE_W-1:0] held_q;
	logic              last_level_q;

	int unsigned queued_ticks   = 0;
	int unsigned accepted_ticks = 0;
	int unsigned mismatch_count = 0;
	int unsigned settings_used  = 0;
	int unsigned kind_seen[4]   = '{0, 0, 0, 0};
	int unsigned send_gap       = 0;
	int unsigned recv_wait      = 0;
	int unsigned next_wait;
	logic        no_gaps        = 1'b0;
	key_sample_t next_sample;
	kpq_result_t want;

	key_press_short_long_qualifier_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_pressed  (key_pressed),
		.encoder_lines(encoder_lines),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.key_code     (key_code),
		.key_byte     (key_byte),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Puts the checker's state where the block's reset puts its own.
	function automatic void reset_qualifier();
		debounce_q   = DEBOUNCE_RESET;
		long_press_q = LONG_PRESS_RESET;
		phase_q      = ST_ARMED;
		count_q      = '0;
		held_q       = '0;
		last_level_q = 1'b0;
	endfunction

	// Advances the qualifier by one tick and returns the event that tick reports.
	// The order of the checks matters: a tick that ends in a report or a bounce
	// also counts its first lockout tick, and with a debounce of one it re-arms
	// on that same tick.
	function automatic kpq_result_t qualify_tick(input logic level,
	                                             input logic [CODE_W-1:0] lines);
		kpq_result_t       ev;
		logic [KIND_W-1:0] kind;
		kind = EV_NONE;
		if (phase_q == ST_ARMED) begin
			// Only a fresh press edge starts a debounce; the count runs from the next tick.
			if (level && !last_level_q) begin
				phase_q = ST_CHECK;
				count_q = '0;
				held_q  = '0;
			end
		end else begin
			if (phase_q == ST_CHECK) begin
				count_q = count_q + 1'b1;
				if (count_q == debounce_q) begin
					if (level) begin
						held_q = {{(BYTE_W - CODE_W){1'b0}}, ~lines} & CODE_MASK;
					end else begin
						// The key was let go before it settled: a bounce, no report.
						phase_q = ST_LOCK;
						count_q = '0;
					end
				end
				if (phase_q == ST_CHECK && count_q > debounce_q) begin
					if (!level) begin
						held_q  = held_q | MARK_SHORT;
						phase_q = ST_LOCK;
						count_q = '0;
						kind    = EV_SHORT;
					end else if (count_q == long_press_q) begin
						held_q  = held_q | MARK_LONG;
						phase_q = ST_LONG;
						count_q = '0;
						kind    = EV_LONG_START;
					end
				end
			end
			if (phase_q == ST_LONG && !level) begin
				held_q  = held_q | MARK_REL;
				phase_q = ST_LOCK;
				kind    = EV_LONG_RELEASE;
			end
			if (phase_q == ST_LOCK) begin
				count_q = count_q + 1'b1;
				if (count_q == debounce_q) begin
					phase_q = ST_ARMED;
					count_q = '0;
				end
			end
		end
		last_level_q = level;
		ev.kind      = kind;
		ev.code      = (kind != EV_NONE) ? held_q[CODE_W-1:0] : '0;
		ev.key_byte  = (kind != EV_NONE) ? held_q : '0;
		return ev;
	endfunction

	// Handshake delay for one item on either side. Roughly a quarter of the
	// draws come back as zero so that back-to-back runs show up too.
	function automatic int unsigned draw_wait();
		if (no_gaps || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	// Sender: takes ticks from the queue, holds each until its transfer, and
	// predicts the event of every tick at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_events.push_back(qualify_tick(key_pressed, encoder_lines));
				accepted_ticks++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					next_sample = tick_queue.pop_front();
					key_pressed   <= next_sample.level;
					encoder_lines <= next_sample.lines;
					in_valid      <= 1'b1;
					send_gap = draw_wait();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer against the oldest owed event and
	// then stalls for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			next_wait = recv_wait;
			if (out_valid && out_ready) begin
				kind_seen[event_kind]++;
				if (expected_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("t=%0t: result with no tick owed: kind %0d code %0d byte %02h",
						         $realtime, event_kind, key_code, key_byte);
					end
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind || key_code !== want.code ||
					    key_byte !== want.key_byte) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("t=%0t: kind %0d/%0d code %0d/%0d byte %02h/%02h (got/expected)",
							         $realtime, event_kind, want.kind, key_code, want.code,
							         key_byte, want.key_byte);
						end
					end
				end
				next_wait = draw_wait();
			end
			if (next_wait > 0) begin
				out_ready <= 1'b0;
				recv_wait = next_wait - 1;
			end else begin
				out_ready <= 1'b1;
				recv_wait = 0;
			end
		end
	end

	// Queues a run of ticks at one level. With jitter set, about one tick in
	// four gets random encoder lines, so the latched code depends on timing.
	task automatic push_run(input logic level, input logic [CODE_W-1:0] lines,
	                        input int unsigned count, input logic jitter);
		key_sample_t s;
		for (int unsigned i = 0; i < count; i++) begin
			s.level = level;
			s.lines = (jitter && $urandom_range(0, 3) == 0) ?
			          CODE_W'($urandom_range(0, 7)) : lines;
			tick_queue.push_back(s);
		end
		queued_ticks += count;
	endtask

	// Waits until every queued tick has been sent and every owed event has come
	// back, then lets the input and output registers run empty.
	task automatic drain_results();
		@(negedge clk);
		while (tick_queue.size() != 0 || in_valid || expected_events.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Writes both timing registers on back-to-back edges while the block is idle.
	task automatic set_timing(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] long_press);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEBOUNCE;
		cfg_data  <= debounce;
		@(posedge clk);
		cfg_index <= CFG_LONG_PRESS;
		cfg_data  <= long_press;
		@(posedge clk);
		cfg_we <= 1'b0;
		debounce_q   = debounce;
		long_press_q = long_press;
		settings_used++;
	endtask

	// Feeds released ticks until the qualifier is armed again, so the next
	// timing change never lands in the middle of a press or a lockout.
	task automatic settle_armed();
		drain_results();
		while (phase_q != ST_ARMED) begin
			push_run(1'b0, CODE_W'($urandom_range(0, 7)), debounce_q + 1, 1'b1);
			drain_results();
		end
	endtask

	// One random key action under the current timing: a bounce, a short press,
	// a long press where one is reachable, or a burst of noise. Each action is
	// followed by a release gap that may end inside the lockout.
	task automatic random_press();
		int unsigned       pick;
		int unsigned       deb;
		int unsigned       lng;
		int unsigned       short_hi;
		int unsigned       hold_len;
		logic [CODE_W-1:0] lines;
		deb      = 32'(debounce_q);
		lng      = 32'(long_press_q);
		pick     = $urandom_range(0, 9);
		lines    = CODE_W'($urandom_range(0, 7));
		short_hi = (lng > deb && lng < deb + 30) ? lng : deb + 30;
		if (pick == 0) begin
			repeat ($urandom_range(1, 8)) begin
				push_run(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 7)), 1, 1'b0);
			end
		end else begin
			if (pick <= 2) begin
				hold_len = $urandom_range(1, deb);
			end else if (pick <= 6 || short_hi != lng) begin
				hold_len = $urandom_range(deb + 1, short_hi);
			end else begin
				hold_len = $urandom_range(lng + 1, lng + 6);
			end
			push_run(1'b1, lines, hold_len, 1'b1);
			push_run(1'b0, lines, $urandom_range(0, 2 * deb + 3), 1'b1);
		end
	endtask

	initial begin
		int unsigned phase_start;
		reset_qualifier();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset timing: a press starts a debounce that cannot finish in time.
		push_run(1'b0, 3'd0, 1, 1'b0);
		push_run(1'b1, 3'd7, 3, 1'b0);
		drain_results();

		// Largest timing values: the debounce keeps counting with the key let go.
		set_timing(16'hFFFF, 16'hFFFF);
		push_run(1'b1, 3'd0, 3, 1'b0);
		push_run(1'b0, 3'd5, 3, 1'b0);
		drain_results();

		// Smallest timing values. The count left over from before is past the new
		// debounce, so the first released tick reports a short press with code 0.
		set_timing(16'd1, 16'd2);
		push_run(1'b0, 3'd4, 1, 1'b0);
		push_run(1'b1, 3'd7, 1, 1'b0);  // press edge
		push_run(1'b1, 3'd0, 1, 1'b0);  // settles, latches code 7
		push_run(1'b0, 3'd0, 1, 1'b0);  // short press, lockout ends on the same tick
		push_run(1'b1, 3'd5, 1, 1'b0);  // press edge
		push_run(1'b1, 3'd2, 3, 1'b0);  // latches code 5, then long press start
		push_run(1'b0, 3'd2, 1, 1'b0);  // long press release
		push_run(1'b1, 3'd6, 1, 1'b0);  // press edge
		push_run(1'b0, 3'd6, 3, 1'b0);  // bounce, re-armed at once
		settle_armed();

		// Edges that arrive during lockout or on the re-arm tick are dropped, and
		// a dip before the debounce tick does not matter if the key is back.
		set_timing(16'd2, 16'd5);
		push_run(1'b1, 3'd3, 3, 1'b0);  // edge, then code 4 latched
		push_run(1'b0, 3'd3, 1, 1'b0);  // short press
		push_run(1'b1, 3'd3, 2, 1'b0);  // edge on the re-arm tick
		push_run(1'b0, 3'd3, 1, 1'b0);
		push_run(1'b1, 3'd1, 1, 1'b0);  // edge
		push_run(1'b0, 3'd1, 1, 1'b0);  // dip
		push_run(1'b1, 3'd1, 4, 1'b0);  // code 6 latched, long press start
		push_run(1'b0, 3'd1, 1, 1'b0);  // long press release
		push_run(1'b1, 3'd1, 1, 1'b0);  // edge inside lockout
		push_run(1'b0, 3'd1, 2, 1'b0);
		settle_armed();

		// Random key activity over a spread of timings, including ones where a
		// long press can never be reached.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					set_timing(16'd3, 16'd9);
				end
				1: begin
					set_timing(16'd4, 16'd4);
				end
				2: begin
					set_timing(16'd6, 16'd3);
				end
				3: begin
					set_timing(16'd1, 16'hFFFF);
				end
				4: begin
					set_timing(16'd2, 16'd7);
				end
				default: begin
					set_timing(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(2, 20)));
				end
			endcase
			no_gaps = (p == 4);
			phase_start = queued_ticks;
			while (queued_ticks - phase_start < 120) begin
				random_press();
				// Now and then the sender holds back until every event is in.
				if ($urandom_range(0, 19) == 0) begin
					drain_results();
				end
			end
			settle_armed();
		end
		no_gaps = 1'b0;
		repeat (10) @(posedge clk);

		$display("Checked %0d ticks under %0d timing settings.", accepted_ticks, settings_used);
		$display("Events seen: %0d short, %0d long start, %0d long release, %0d mismatches.",
		         kind_seen[EV_SHORT], kind_seen[EV_LONG_START], kind_seen[EV_LONG_RELEASE],
		         mismatch_count);
		if (mismatch_count == 0 && expected_events.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: several times the slowest expected run.
	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

endmodule
